// File: rtl/srtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insert descending queue package
// Record layout, cell control types, command codes and sequencer states
// shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
package srtq_pkg;

   localparam int POWER_W  = 8;
   localparam int STATUS_W = 16;
   localparam int TAG_W    = 8;
   localparam int POS_W    = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [STATUS_W-1:0] status;
      logic [POWER_W-1:0]  power;
   } rec_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [POWER_W-1:0]  key;
      rec_type             new_rec;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

// File: rtl/srtq_cell.sv
// ----------------------------------------------------------------------------
// Sorted insert descending queue cell
// One slot of the sorted chain. On an insert it keeps its record, takes the
// new one, or takes its left neighbor's; on a drain shift it takes the right
// neighbor's record.
// ----------------------------------------------------------------------------
module srtq_cell (
   input  logic                  clock,
   input  srtq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_keep,
   input  srtq_pkg::rec_type     left_rec,
   input  srtq_pkg::rec_type     right_rec,
   output logic                  keep,
   output srtq_pkg::rec_type     rec
);

   srtq_pkg::rec_type rec_ff;
   srtq_pkg::rec_type rec_in;

   // Equal powers stay ahead of the new record, which keeps arrival order.
   assign keep = occupied && (rec_ff.power >= ctrl.key);
   assign rec  = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      case (ctrl.op)
         srtq_pkg::CELL_INSERT: begin
            if (keep) begin
               rec_in = rec_ff;
            end else if (left_keep) begin
               rec_in = ctrl.new_rec;
            end else begin
               rec_in = left_rec;
            end
         end
         srtq_pkg::CELL_SHIFT: begin
            rec_in = right_rec;
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// File: rtl/sorted_insert_descending_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted insert descending queue unit
// Holds up to DEPTH records sorted by power, largest first, in a chain of
// cells, and drains them in order on request.
// ----------------------------------------------------------------------------
// Usage:
// A request on the req_ channel is an insert (req_tuser low) or a drain
// (req_tuser high). On an insert all cells compare the new power in
// parallel and the chain opens a gap at the right place, so inserts
// may follow back to back. Its status is first_char times power.
// An insert into a full store is dropped and sets a sticky flag that is
// reported on rsp_tuser; only reset clears it.
// A drain emits one record per cycle through an output register, cell zero
// first while the chain shifts toward the head. The first record is valid
// once the state register has entered the drain state and the output
// register has loaded it. req_tready is low for the whole drain; rsp_tlast
// marks the final one. A drain of an empty store gives no response.
// When the receiver stalls, the output register holds and the chain stops
// shifting. Reset empties the store and clears the flag.
// ----------------------------------------------------------------------------
module sorted_insert_descending_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // power[7:0], first_char[15:8], tag[23:16]
   input  logic        req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // power_out[7:0], status_product[23:8],
                                    // tag_out[31:24], position[35:32], zero fill
   output logic        rsp_tlast,
   output logic        rsp_tuser    // dropped[0]
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   srtq_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [srtq_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                    overflow_ff, overflow_in;

   logic                    out_valid_ff, out_valid_in;
   srtq_pkg::rec_type       out_rec_ff, out_rec_in;
   logic [srtq_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_drop_ff, out_drop_in;

   srtq_pkg::cell_ctrl_type ctrl;
   srtq_pkg::rec_type       new_rec;
   srtq_pkg::rec_type       cell_rec [DEPTH];
   logic [DEPTH-1:0]        cell_keep;

   logic                    req_accept;
   logic                    is_full;
   logic                    load;

   assign req_accept = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign load       = (state_ff == srtq_pkg::ST_DRAIN) && (!out_valid_ff || rsp_tready);

   assign new_rec.power  = req_tdata[7:0];
   assign new_rec.status = 16'(req_tdata[7:0]) * 16'(req_tdata[15:8]);
   assign new_rec.tag    = req_tdata[23:16];

   always_comb begin
      ctrl.key     = req_tdata[7:0];
      ctrl.new_rec = new_rec;
      ctrl.op      = srtq_pkg::CELL_HOLD;
      if (load) begin
         ctrl.op = srtq_pkg::CELL_SHIFT;
      end else if (req_accept && req_tuser == srtq_pkg::CMD_INSERT && !is_full) begin
         ctrl.op = srtq_pkg::CELL_INSERT;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      srtq_pkg::rec_type left_rec;
      srtq_pkg::rec_type right_rec;
      logic              left_keep;

      if (i == 0) begin : g_head
         assign left_rec  = new_rec;
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_rec  = cell_rec[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_rec = new_rec;
      end else begin : g_inner
         assign right_rec = cell_rec[i+1];
      end

      srtq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (CNT_W'(i) < count_ff),
         .left_keep (left_keep),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .keep      (cell_keep[i]),
         .rec       (cell_rec[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      overflow_in  = overflow_ff;
      out_valid_in = out_valid_ff;
      out_rec_in   = out_rec_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;
      req_tready   = 1'b0;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         srtq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               if (req_tuser == srtq_pkg::CMD_INSERT) begin
                  if (is_full) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff != '0) begin
                  state_in = srtq_pkg::ST_DRAIN;
                  pos_in   = '0;
               end
            end
         end
         srtq_pkg::ST_DRAIN: begin
            if (load) begin
               out_valid_in = 1'b1;
               out_rec_in   = cell_rec[0];
               out_pos_in   = pos_ff;
               out_last_in  = (count_ff == CNT_W'(1));
               out_drop_in  = overflow_ff;
               pos_in       = pos_ff + srtq_pkg::POS_W'(1);
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = srtq_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = srtq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srtq_pkg::ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff  <= out_rec_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_pos_ff, out_rec_ff.tag, out_rec_ff.status,
                        out_rec_ff.power};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_drop_ff;

`ifndef NO_ASSERTIONS
   // The fill count never passes the number of cells.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count exceeds depth");

   // A drain is only running while records remain.
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == srtq_pkg::ST_DRAIN |-> count_ff != '0)
      else $error("drain running on an empty store");

   // Emitting the final record ends the drain.
   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      load && count_ff == CNT_W'(1) |=> state_ff == srtq_pkg::ST_IDLE && count_ff == '0)
      else $error("drain did not end after the final record");

   // The loss flag is sticky until reset.
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("loss flag cleared without reset");

   // An insert into a full store leaves the count alone and raises the flag.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == srtq_pkg::CMD_INSERT && is_full
      |=> overflow_ff && count_ff == CNT_W'(DEPTH))
      else $error("insert into a full store was not dropped");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted insert descending queue unit testbench
// Sends insert and drain requests with random gaps while the receiver
// stalls at random. Each accepted request updates a software copy of the
// sorted store. Each drain queues the records it must return, and every
// record that comes back is compared field by field against the oldest one.
// ----------------------------------------------------------------------------

typedef struct {
   srtq_pkg::rec_type                rec;
   logic [srtq_pkg::POS_W-1:0]       position;
   logic                             last;
   logic                             dropped;
} drained_record_type;

class record_order_tracker;
   int                 capacity;
   srtq_pkg::rec_type  stored[$];
   logic               overflow_seen;
   drained_record_type awaited[$];
   int                 mismatches;

   function new(int depth);
      capacity      = depth;
      overflow_seen = 1'b0;
      mismatches    = 0;
   endfunction

   function void note_request(logic cmd, logic [srtq_pkg::POWER_W-1:0] power,
                              logic [7:0] first_char,
                              logic [srtq_pkg::TAG_W-1:0] tag);
      srtq_pkg::rec_type  rec;
      drained_record_type out;
      int                 slot;
      if (cmd == srtq_pkg::CMD_INSERT) begin
         if (stored.size() >= capacity) begin
            overflow_seen = 1'b1;
         end else begin
            rec.power  = power;
            rec.status = 16'(power) * 16'(first_char);
            rec.tag    = tag;
            // A new record goes behind every record of equal or larger power.
            slot = 0;
            while (slot < stored.size() && stored[slot].power >= power) slot++;
            stored.insert(slot, rec);
         end
      end else begin
         foreach (stored[i]) begin
            out.rec      = stored[i];
            out.position = srtq_pkg::POS_W'(i);
            out.last     = (i == stored.size() - 1);
            out.dropped  = overflow_seen;
            awaited.push_back(out);
         end
         stored.delete();
      end
   endfunction

   function void check_record(logic [39:0] data, logic last, logic dropped);
      drained_record_type want;
      srtq_pkg::rec_type  got;
      got = data[31:0];
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected record power=%0d status=%0d tag=%0d pos=%0d",
                     $realtime, got.power, got.status, got.tag, data[35:32]);
         return;
      end
      want = awaited.pop_front();
      if (got.power !== want.rec.power || got.status !== want.rec.status ||
          got.tag !== want.rec.tag || data[35:32] !== want.position ||
          last !== want.last || dropped !== want.dropped) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: record mismatch", $realtime);
            $display("   expected power=%0d status=%0d tag=%0d pos=%0d last=%0b dropped=%0b",
                     want.rec.power, want.rec.status, want.rec.tag, want.position,
                     want.last, want.dropped);
            $display("   actual   power=%0d status=%0d tag=%0d pos=%0d last=%0b dropped=%0b",
                     got.power, got.status, got.tag, data[35:32], last, dropped);
         end
      end
   endfunction
endclass

module tb;

   localparam int STORE_DEPTH = 16;
   localparam int IDLE_LIMIT  = 1000;
   localparam int RANDOM_REQS = 200;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   record_order_tracker tracker = new(STORE_DEPTH);

   bit smooth;
   int sent;
   int idle_cycles;

   sorted_insert_descending_queue_unit #(
      .DEPTH(STORE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none at all during smooth stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (smooth || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic cmd, logic [7:0] power, logic [7:0] first_char,
                               logic [7:0] tag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {tag, first_char, power};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   task automatic insert_record(logic [7:0] power, logic [7:0] first_char, logic [7:0] tag);
      send_request(srtq_pkg::CMD_INSERT, power, first_char, tag);
   endtask

   task automatic drain_store();
      send_request(srtq_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Picks a power either from a few spread values, to force ties, or freely.
   function automatic logic [7:0] pick_power(bit tie_prone);
      if (tie_prone) return 8'($urandom_range(0, 3) * 85);
      return 8'($urandom);
   endfunction

   initial begin
      int inserts;
      int r;
      bit ties;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = srtq_pkg::CMD_INSERT;
      rsp_tready = 1'b0;
      smooth     = 1'b0;
      sent       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty drain, field extremes and equal powers kept in arrival order.
      drain_store();
      insert_record(8'd0, 8'd0, 8'd0);
      insert_record(8'd255, 8'd255, 8'd255);
      insert_record(8'd128, 8'd7, 8'd1);
      insert_record(8'd128, 8'd9, 8'd2);
      drain_store();

      // Fill the store, then one more insert is lost and the flag sticks.
      for (int i = 0; i < STORE_DEPTH; i++)
         insert_record(pick_power(1'b1), 8'($urandom), 8'(i));
      insert_record(8'd200, 8'd200, 8'd99);
      drain_store();

      while (sent < RANDOM_REQS) begin
         smooth = ($urandom_range(0, 3) == 0);
         ties   = ($urandom_range(0, 2) == 0);
         r      = $urandom_range(0, 9);
         if (r == 0)      inserts = 0;
         else if (r <= 7) inserts = $urandom_range(1, 8);
         else if (r == 8) inserts = $urandom_range(9, STORE_DEPTH);
         else             inserts = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
         repeat (inserts) insert_record(pick_power(ties), 8'($urandom), 8'($urandom));
         drain_store();
      end
      smooth     = 1'b0;
      req_tvalid = 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (STORE_DEPTH + 8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser, req_tdata[7:0], req_tdata[15:8],
                                 req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_record(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
